// ===== design/tlr_pkg.sv =====
// Shared types and constants of the thick line rasterizer.
// Used by tlr_line, tlr_ctrl and thick_line_rasterizer_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlr_pkg;

    localparam int COORD_BITS_DEF = 13;
    localparam int MAX_BRUSH_DEF  = 7;

    localparam int CANVAS_BITS = 13;
    localparam int OFS_BITS    = 3;
    localparam int HALF_BITS   = 2;

    localparam logic [CANVAS_BITS-1:0] CANVAS_W_RESET = 13'd1024;
    localparam logic [CANVAS_BITS-1:0] CANVAS_H_RESET = 13'd768;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic REG_CANVAS_W = 1'b0;
    localparam logic REG_CANVAS_H = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NULL,
        ST_STAMP,
        ST_ADVANCE
    } seq_state_t;

    typedef struct packed {
        logic load;
        logic advance;
    } line_ctrl_t;

    typedef struct packed {
        logic                 active;
        logic                 done;
        logic [HALF_BITS-1:0] half;
    } line_stat_t;

    typedef struct packed {
        logic                       valid;
        logic                       null_beat;
        logic                       last;
        logic signed [OFS_BITS-1:0] ox;
        logic signed [OFS_BITS-1:0] oy;
    } emit_t;

endpackage

`default_nettype wire

// ===== design/thick_line_rasterizer_top.sv =====
// Top level of the thick line rasterizer: canvas registers, pixel offset and
// clip unit, output register. Instantiates tlr_ctrl and tlr_line; uses tlr_pkg.
//
//   port group   dir   flow
//   s_*          in    start / step beats, valid-ready
//   m_*          out   stamp pixel beats, valid-ready
//   cfg_*        in    canvas width / height writes, no wait
//
// A start beat loads the line and leaves the sequencer idle and ready.
// A step beat stamps (2*half+1)^2 pixels, one a cycle while the output is
// free, through the shared offset/clip unit, then makes one error update.
// A step with no active line sends a single null beat with m_line_done set.
// Reset is synchronous: no line is active and the canvas is 1024 by 768.
`timescale 1ns / 1ps
`default_nettype none

module thick_line_rasterizer_top
    import tlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int MAX_BRUSH  = MAX_BRUSH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_opcode,
    input  wire logic signed [COORD_BITS-1:0] s_first_x,
    input  wire logic signed [COORD_BITS-1:0] s_first_y,
    input  wire logic signed [COORD_BITS-1:0] s_final_x,
    input  wire logic signed [COORD_BITS-1:0] s_final_y,
    input  wire logic        [2:0]            s_brush_size,
    input  wire logic        [31:0]           s_ink,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [COORD_BITS:0]        m_pixel_x,
    output logic signed [COORD_BITS:0]        m_pixel_y,
    output logic        [31:0]                m_pixel_ink,
    output logic                              m_plot,
    output logic                              m_stamp_last,
    output logic                              m_line_done,
    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_index,
    input  wire logic [CANVAS_BITS-1:0]       cfg_wdata
);

    localparam int PIX_W = COORD_BITS + 1;

    logic [CANVAS_BITS-1:0] canvas_w_reg, canvas_h_reg;

    line_ctrl_t ctrl;
    line_stat_t stat;
    emit_t      emit;
    logic       out_free;

    logic signed [COORD_BITS-1:0] cur_x, cur_y;
    logic        [31:0]           line_ink;
    logic signed [PIX_W-1:0]      px, py;
    logic                         plot;

    logic                    m_valid_reg;
    logic signed [PIX_W-1:0] m_pixel_x_reg, m_pixel_y_reg;
    logic        [31:0]      m_pixel_ink_reg;
    logic                    m_plot_reg, m_stamp_last_reg, m_line_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            canvas_w_reg <= CANVAS_W_RESET;
            canvas_h_reg <= CANVAS_H_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_CANVAS_W) begin
                canvas_w_reg <= cfg_wdata;
            end
            if (cfg_index == REG_CANVAS_H) begin
                canvas_h_reg <= cfg_wdata;
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    tlr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .out_free (out_free),
        .stat     (stat),
        .s_ready  (s_ready),
        .ctrl     (ctrl),
        .emit     (emit)
    );

    tlr_line #(
        .COORD_BITS (COORD_BITS),
        .MAX_BRUSH  (MAX_BRUSH)
    ) u_line (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .first_x    (s_first_x),
        .first_y    (s_first_y),
        .final_x    (s_final_x),
        .final_y    (s_final_y),
        .brush_size (s_brush_size),
        .ink        (s_ink),
        .stat       (stat),
        .cur_x      (cur_x),
        .cur_y      (cur_y),
        .line_ink   (line_ink)
    );

    assign px = PIX_W'(cur_x) + PIX_W'(emit.ox);
    assign py = PIX_W'(cur_y) + PIX_W'(emit.oy);

    assign plot = !px[PIX_W-1] && !py[PIX_W-1] &&
                  ({{CANVAS_BITS{1'b0}}, px} < {{PIX_W{1'b0}}, canvas_w_reg}) &&
                  ({{CANVAS_BITS{1'b0}}, py} < {{PIX_W{1'b0}}, canvas_h_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            if (emit.null_beat) begin
                m_pixel_x_reg   <= '0;
                m_pixel_y_reg   <= '0;
                m_pixel_ink_reg <= '0;
                m_plot_reg      <= 1'b0;
                m_line_done_reg <= 1'b1;
            end else begin
                m_pixel_x_reg   <= px;
                m_pixel_y_reg   <= py;
                m_pixel_ink_reg <= line_ink;
                m_plot_reg      <= plot;
                m_line_done_reg <= stat.done;
            end
            m_stamp_last_reg <= emit.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_x    = m_pixel_x_reg;
    assign m_pixel_y    = m_pixel_y_reg;
    assign m_pixel_ink  = m_pixel_ink_reg;
    assign m_plot       = m_plot_reg;
    assign m_stamp_last = m_stamp_last_reg;
    assign m_line_done  = m_line_done_reg;

`ifndef SYNTHESIS
    a_step_drops_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_opcode == OP_STEP |=> !s_ready)
        else $error("step beat did not drop ready");

    a_start_keeps_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_opcode == OP_START |=> s_ready)
        else $error("start beat left the sequencer busy");

    a_emit_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.valid |-> out_free)
        else $error("pixel beat overwrote a pending result");

    a_plot_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_plot |-> !m_pixel_x[PIX_W-1] && !m_pixel_y[PIX_W-1])
        else $error("plotted pixel has a negative coordinate");
`endif

endmodule

`default_nettype wire

// ===== design/tlr_line.sv =====
// Line state of the rasterizer: endpoints, spans, error term, brush and ink.
// Loads on a start beat and takes one error-rule step per advance. Uses tlr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlr_line
    import tlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int MAX_BRUSH  = MAX_BRUSH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire line_ctrl_t                   ctrl,
    input  wire logic signed [COORD_BITS-1:0] first_x,
    input  wire logic signed [COORD_BITS-1:0] first_y,
    input  wire logic signed [COORD_BITS-1:0] final_x,
    input  wire logic signed [COORD_BITS-1:0] final_y,
    input  wire logic        [2:0]            brush_size,
    input  wire logic        [31:0]           ink,
    output line_stat_t                        stat,
    output logic signed [COORD_BITS-1:0]      cur_x,
    output logic signed [COORD_BITS-1:0]      cur_y,
    output logic        [31:0]                line_ink
);

    localparam int ERR_W = COORD_BITS + 3;
    localparam logic [2:0] MAX_B = 3'(MAX_BRUSH);
    localparam logic signed [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] goal_x_reg, goal_y_reg;
    logic signed [ERR_W-1:0]      span_x_reg, span_y_reg;
    logic signed [ERR_W-1:0]      span_x_next, span_y_next;
    logic signed [ERR_W-1:0]      err_reg, err_next;
    logic        [1:0]            dirs_reg;
    logic        [HALF_BITS-1:0]  half_reg;
    logic        [31:0]           ink_reg;
    logic                         active_reg, active_next;

    logic signed [ERR_W-1:0] fx_w, fy_w, tx_w, ty_w;
    logic signed [ERR_W:0]   e2;
    logic signed [ERR_W:0]   neg_span_y_w, span_x_w;
    logic        [2:0]       brush_cap;
    logic                    done;
    logic                    step_x, step_y;

    assign fx_w = ERR_W'(first_x);
    assign fy_w = ERR_W'(first_y);
    assign tx_w = ERR_W'(final_x);
    assign ty_w = ERR_W'(final_y);

    assign span_x_next = (tx_w > fx_w) ? (tx_w - fx_w) : (fx_w - tx_w);
    assign span_y_next = (ty_w > fy_w) ? (ty_w - fy_w) : (fy_w - ty_w);
    assign brush_cap   = (brush_size > MAX_B) ? MAX_B : brush_size;

    assign done = (cur_x_reg == goal_x_reg) && (cur_y_reg == goal_y_reg);

    assign e2           = (ERR_W + 1)'(err_reg) <<< 1;
    assign neg_span_y_w = -((ERR_W + 1)'(span_y_reg));
    assign span_x_w     = (ERR_W + 1)'(span_x_reg);
    assign step_x       = e2 > neg_span_y_w;
    assign step_y       = e2 < span_x_w;

    always_comb begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        err_next    = err_reg;
        active_next = active_reg;
        if (ctrl.advance) begin
            if (done) begin
                active_next = 1'b0;
            end else begin
                if (step_x) begin
                    cur_x_next = dirs_reg[0] ? cur_x_reg + COORD_ONE : cur_x_reg - COORD_ONE;
                end
                if (step_x && step_y) begin
                    err_next = err_reg - span_y_reg + span_x_reg;
                end else if (step_x) begin
                    err_next = err_reg - span_y_reg;
                end else if (step_y) begin
                    err_next = err_reg + span_x_reg;
                end
                if (step_y) begin
                    cur_y_next = dirs_reg[1] ? cur_y_reg + COORD_ONE : cur_y_reg - COORD_ONE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (ctrl.load) begin
            active_reg <= 1'b1;
        end else begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cur_x_reg  <= first_x;
            cur_y_reg  <= first_y;
            goal_x_reg <= final_x;
            goal_y_reg <= final_y;
            span_x_reg <= span_x_next;
            span_y_reg <= span_y_next;
            err_reg    <= span_x_next - span_y_next;
            dirs_reg   <= {first_y < final_y, first_x < final_x};
            half_reg   <= brush_cap[2:1];
            ink_reg    <= ink;
        end else begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            err_reg   <= err_next;
        end
    end

    assign stat.active = active_reg;
    assign stat.done   = done;
    assign stat.half   = half_reg;
    assign cur_x       = cur_x_reg;
    assign cur_y       = cur_y_reg;
    assign line_ink    = ink_reg;

endmodule

`default_nettype wire

// ===== design/tlr_ctrl.sv =====
// Sequencer of the rasterizer: input handshake, stamp offset counters and
// the beat/advance schedule of one step. Uses tlr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlr_ctrl
    import tlr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_opcode,
    input  wire logic       out_free,
    input  wire line_stat_t stat,
    output logic            s_ready,
    output line_ctrl_t      ctrl,
    output emit_t           emit
);

    localparam logic signed [OFS_BITS-1:0] OFS_ONE = OFS_BITS'(1);

    seq_state_t state_reg, state_next;

    logic signed [OFS_BITS-1:0] ox_reg, ox_next;
    logic signed [OFS_BITS-1:0] oy_reg, oy_next;
    logic signed [OFS_BITS-1:0] h;
    logic                       accept;
    logic                       last;

    assign h      = signed'({1'b0, stat.half});
    assign accept = s_valid && (state_reg == ST_IDLE);
    assign last   = (ox_reg == h) && (oy_reg == h);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_opcode == OP_STEP) begin
                    state_next = stat.active ? ST_STAMP : ST_NULL;
                end
            end
            ST_NULL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_STAMP: begin
                if (out_free && last) begin
                    state_next = ST_ADVANCE;
                end
            end
            ST_ADVANCE: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        ctrl.load      = 1'b0;
        ctrl.advance   = 1'b0;
        emit.valid     = 1'b0;
        emit.null_beat = 1'b0;
        emit.last      = 1'b0;
        emit.ox        = ox_reg;
        emit.oy        = oy_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                ctrl.load = accept && (s_opcode == OP_START);
            end
            ST_NULL: begin
                emit.valid     = out_free;
                emit.null_beat = 1'b1;
                emit.last      = 1'b1;
            end
            ST_STAMP: begin
                emit.valid = out_free;
                emit.last  = last;
            end
            ST_ADVANCE: begin
                ctrl.advance = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        ox_next = ox_reg;
        oy_next = oy_reg;
        if (state_reg == ST_IDLE) begin
            ox_next = -h;
            oy_next = -h;
        end else if (state_reg == ST_STAMP && out_free && !last) begin
            if (ox_reg == h) begin
                ox_next = -h;
                oy_next = oy_reg + OFS_ONE;
            end else begin
                ox_next = ox_reg + OFS_ONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        ox_reg <= ox_next;
        oy_reg <= oy_next;
    end

endmodule

`default_nettype wire
